FILE: rtl/core/fmts_pkg.sv
// Shared constants, codes and control structs for the flight mode target smoother.
`timescale 1ns / 1ps
`default_nettype none

package fmts_pkg;

	// Field widths.
	localparam int MODE_W  = 3;
	localparam int ANG_W   = 16;
	localparam int THR_W   = 12;
	localparam int ATHR_W  = 16;
	localparam int DT_W    = 16;
	localparam int TGT_W   = 19;
	localparam int DB_W    = 15;
	localparam int TAU_W   = 22;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 22;

	// Stream packing: input tdata holds the stick and navigator fields and the tick length,
	// output tdata holds the two targets and the throttle.
	localparam int IN_RAW_W   = 4 * ANG_W + THR_W + ATHR_W + DT_W;
	localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W  = 2 * TGT_W + THR_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 2;

	// Arithmetic widths.
	localparam int DIFF_W    = TGT_W + 1;
	localparam int PROD_W    = DIFF_W + DT_W;
	localparam int DEN_W     = TAU_W + 1;
	localparam int DIV_NUM_W = PROD_W + 2;
	localparam int DIV_DEN_W = DEN_W + 1;
	localparam int DIV_Q_W   = DIFF_W;
	localparam int DIV_CNT_W = $clog2(DIV_Q_W);
	localparam int SUM_W     = TGT_W + 3;

	// Manual stick scaling: round(stick * 100 / 9) done as (mag * 200 + 9) / 18.
	localparam logic [DT_W-1:0]      MAN_MUL  = DT_W'(200);
	localparam logic [DIV_NUM_W-1:0] MAN_BIAS = DIV_NUM_W'(9);
	localparam logic [DIV_DEN_W-1:0] MAN_DEN  = DIV_DEN_W'(18);

	// Navigator throttle: 1000 + round(frac * 1000 / 65536).
	localparam logic [9:0]  NAV_SCALE = 10'd1000;
	localparam logic [25:0] NAV_HALF  = 26'd32768;
	localparam logic [10:0] NAV_BASE  = 11'd1000;

	localparam logic signed [SUM_W-1:0] TGT_MAX = SUM_W'(262143);
	localparam logic signed [SUM_W-1:0] TGT_MIN = -SUM_W'(262144);

	// Flight modes.
	localparam logic [MODE_W-1:0] FM_MANUAL = 3'd0;
	localparam logic [MODE_W-1:0] FM_ANGLE  = 3'd1;
	localparam logic [MODE_W-1:0] FM_HOLD   = 3'd2;
	localparam logic [MODE_W-1:0] FM_AUTO   = 3'd3;
	localparam logic [MODE_W-1:0] FM_HOME   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAU_PILOT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAU_AUTO  = 2'd2;

	localparam logic [DB_W-1:0]  DEADBAND_RST  = DB_W'(768);
	localparam logic [TAU_W-1:0] TAU_PILOT_RST = TAU_W'(100000);
	localparam logic [TAU_W-1:0] TAU_AUTO_RST  = TAU_W'(500000);

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic select;
		logic mul;
		logic div_start;
		logic write;
		logic lane;
		logic out_load;
	} fmts_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} fmts_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/fmts_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fmts_div import fmts_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	output logic                      done,
	output logic [DIV_Q_W-1:0]        quo
);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_Q_W-1:0]   lo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   trial_sub;
	logic                 fits;

	// The caller guarantees the quotient fits DIV_Q_W bits, so the upper
	// numerator bits start below the divisor.
	assign trial     = {rem_q, lo_q[DIV_Q_W-1]};
	assign fits      = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
			lo_q  <= num[DIV_Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			lo_q  <= {lo_q[DIV_Q_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = lo_q;

endmodule

`default_nettype wire

FILE: rtl/core/fmts_ctrl.sv
// Sequencing state machine for the flight mode target smoother.
`timescale 1ns / 1ps
`default_nettype none

module fmts_ctrl import fmts_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire fmts_sts_t sts,
	output fmts_cmd_t      cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SELECT = 7'b0000010,
		ST_MUL    = 7'b0000100,
		ST_LOAD   = 7'b0001000,
		ST_DIV    = 7'b0010000,
		ST_WRITE  = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   lane_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.lane = lane_q;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SELECT;
				end
			end
			ST_SELECT: begin
				cmd.select = 1'b1;
				state_d    = sts.need_div ? ST_MUL : ST_OUT;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = lane_q ? ST_OUT : ST_MUL;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.select) begin
				lane_q <= 1'b0;
			end else if (cmd.write) begin
				lane_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/fmts_dp.sv
// Datapath: configuration, target selection, filter arithmetic and output register.
`timescale 1ns / 1ps
`default_nettype none

module fmts_dp import fmts_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DAT_W-1:0]  cfg_dat,
	input  wire logic [IN_DATA_W-1:0]  in_data,
	input  wire logic [MODE_W-1:0]     in_mode,
	input  wire fmts_cmd_t             cmd,
	output fmts_sts_t                  sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_DATA_W-1:0]      out_data,
	output logic [OUT_USER_W-1:0]      out_user
);

	// Configuration registers.
	logic [DB_W-1:0]  deadband_q;
	logic [TAU_W-1:0] tau_pilot_q;
	logic [TAU_W-1:0] tau_auto_q;

	// Captured input beat.
	logic [MODE_W-1:0]       mode_q;
	logic signed [ANG_W-1:0] s_roll_q, s_pitch_q, a_roll_q, a_pitch_q;
	logic [THR_W-1:0]        s_thr_q;
	logic [ATHR_W-1:0]       a_thr_q;
	logic [DT_W-1:0]         dt_q;

	// Per-tick selection.
	logic signed [ANG_W-1:0] raw_roll_q, raw_pitch_q;
	logic                    manual_q;
	logic [THR_W-1:0]        thr_q;
	logic [DEN_W-1:0]        den_q;
	logic                    pid_reset_q;
	logic [MODE_W-1:0]       last_mode_q;

	// Filter state and lane arithmetic.
	logic signed [TGT_W-1:0] smooth_roll_q, smooth_pitch_q;
	logic [PROD_W-1:0]       prod_q;
	logic                    neg_q;

	// Output register.
	logic                    out_valid_q;
	logic signed [TGT_W-1:0] out_roll_q, out_pitch_q;
	logic [THR_W-1:0]        out_thr_q;
	logic                    out_bypass_q, out_reset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q  <= DEADBAND_RST;
			tau_pilot_q <= TAU_PILOT_RST;
			tau_auto_q  <= TAU_AUTO_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DEADBAND:  deadband_q  <= cfg_dat[DB_W-1:0];
				REG_TAU_PILOT: tau_pilot_q <= cfg_dat[TAU_W-1:0];
				REG_TAU_AUTO:  tau_auto_q  <= cfg_dat[TAU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q    <= in_mode;
			s_roll_q  <= in_data[15:0];
			s_pitch_q <= in_data[31:16];
			s_thr_q   <= in_data[43:32];
			a_roll_q  <= in_data[59:44];
			a_pitch_q <= in_data[75:60];
			a_thr_q   <= in_data[91:76];
			dt_q      <= in_data[107:92];
		end
	end

	// Mode decode and raw target selection.
	logic [ANG_W-1:0]        s_roll_mag, s_pitch_mag;
	logic                    override;
	logic [25:0]             nav_prod;
	logic [THR_W-1:0]        nav_thr;
	logic                    use_auto, use_stick, is_manual;
	logic signed [ANG_W-1:0] sel_roll, sel_pitch;
	logic [THR_W-1:0]        sel_thr;
	logic [TAU_W-1:0]        sel_tau;

	assign s_roll_mag  = s_roll_q[ANG_W-1] ? ANG_W'(-s_roll_q) : ANG_W'(s_roll_q);
	assign s_pitch_mag = s_pitch_q[ANG_W-1] ? ANG_W'(-s_pitch_q) : ANG_W'(s_pitch_q);
	assign override    = (s_roll_mag > ANG_W'(deadband_q)) || (s_pitch_mag > ANG_W'(deadband_q));
	assign nav_prod    = a_thr_q * NAV_SCALE;
	assign nav_thr     = THR_W'(NAV_BASE + 11'((nav_prod + NAV_HALF) >> 16));

	always_comb begin
		use_auto  = 1'b0;
		use_stick = 1'b0;
		is_manual = 1'b0;
		case (mode_q) inside
			FM_MANUAL:         is_manual = 1'b1;
			FM_ANGLE:          use_stick = 1'b1;
			FM_HOLD: begin
				use_stick = override;
				use_auto  = !override;
			end
			FM_AUTO, FM_HOME: use_auto = 1'b1;
			default: begin
			end
		endcase
		if (is_manual || use_stick) begin
			sel_roll  = s_roll_q;
			sel_pitch = s_pitch_q;
		end else if (use_auto) begin
			sel_roll  = a_roll_q;
			sel_pitch = a_pitch_q;
		end else begin
			sel_roll  = '0;
			sel_pitch = '0;
		end
		sel_thr = use_auto ? nav_thr : s_thr_q;
		sel_tau = use_auto ? tau_auto_q : tau_pilot_q;
	end

	assign sts.need_div = is_manual || ((sel_tau != '0) && (dt_q != '0));

	always_ff @(posedge clk) begin
		if (cmd.select) begin
			raw_roll_q  <= sel_roll;
			raw_pitch_q <= sel_pitch;
			manual_q    <= is_manual;
			thr_q       <= sel_thr;
			den_q       <= DEN_W'(sel_tau) + DEN_W'(dt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mode_q <= FM_MANUAL;
			pid_reset_q <= 1'b0;
		end else if (cmd.select) begin
			last_mode_q <= mode_q;
			pid_reset_q <= (mode_q != last_mode_q);
		end
	end

	// Lane arithmetic: magnitude times tick (or the manual scale), then divide.
	logic signed [ANG_W-1:0]  lane_raw;
	logic signed [TGT_W-1:0]  lane_cur;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        diff_mag;
	logic [DT_W-1:0]          mul_b;
	logic [DIV_NUM_W-1:0]     div_num;
	logic [DIV_DEN_W-1:0]     div_den;
	logic                     div_done;
	logic [DIV_Q_W-1:0]       div_quo;

	assign lane_raw = cmd.lane ? raw_pitch_q : raw_roll_q;
	assign lane_cur = cmd.lane ? smooth_pitch_q : smooth_roll_q;
	assign diff     = manual_q ? DIFF_W'(lane_raw) : DIFF_W'(lane_raw) - DIFF_W'(lane_cur);
	assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign mul_b    = manual_q ? MAN_MUL : dt_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= diff_mag * mul_b;
			neg_q  <= diff[DIFF_W-1];
		end
	end

	// Rounding to nearest: manual adds 9 over 18; the filter adds den over 2*den.
	assign div_num = manual_q ? DIV_NUM_W'(prod_q) + MAN_BIAS
	                          : DIV_NUM_W'({prod_q, 1'b0}) + DIV_NUM_W'(den_q);
	assign div_den = manual_q ? MAN_DEN : {den_q, 1'b0};

	fmts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign sts.div_done = div_done;

	logic signed [SUM_W-1:0] step_base, step_delta, step_sum;
	logic signed [TGT_W-1:0] step_sat;

	assign step_base  = manual_q ? '0 : SUM_W'(lane_cur);
	assign step_delta = neg_q ? -SUM_W'(div_quo) : SUM_W'(div_quo);
	assign step_sum   = step_base + step_delta;
	assign step_sat   = (step_sum > TGT_MAX) ? TGT_W'(TGT_MAX) :
	                    (step_sum < TGT_MIN) ? TGT_W'(TGT_MIN) : TGT_W'(step_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_roll_q  <= '0;
			smooth_pitch_q <= '0;
		end else if (cmd.select && !sts.need_div) begin
			smooth_roll_q  <= TGT_W'(sel_roll);
			smooth_pitch_q <= TGT_W'(sel_pitch);
		end else if (cmd.write) begin
			if (cmd.lane) begin
				smooth_pitch_q <= step_sat;
			end else begin
				smooth_roll_q <= step_sat;
			end
		end
	end

	// Output register.
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_roll_q   <= smooth_roll_q;
			out_pitch_q  <= smooth_pitch_q;
			out_thr_q    <= thr_q;
			out_bypass_q <= manual_q;
			out_reset_q  <= pid_reset_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = OUT_DATA_W'({out_thr_q, out_pitch_q, out_roll_q});
	assign out_user  = {out_reset_q, out_bypass_q};

endmodule

`default_nettype wire

FILE: rtl/core/flight_mode_target_smoother.sv
// Top level of the flight mode target smoother.
//
// One input beat is one control tick: the flight mode on s_axis_tuser, and the stick angles,
// stick throttle, navigator angles, navigator throttle fraction and tick length on
// s_axis_tdata. Each tick gives exactly one output beat with the smoothed roll and pitch
// targets and the selected throttle on m_axis_tdata, and the PID bypass and PID reset flags
// on m_axis_tuser.
// The block works on one tick at a time. A tick that needs filtering or manual scaling runs
// one shared serial divider twice (roll, then pitch), one quotient bit per cycle, 20 bits;
// the result is loaded into the output register after the pitch write, and the next input
// beat can be taken once it is loaded. With the filter bypassed (zero tick length or a zero
// time constant, outside manual mode) the selected targets skip the divider and go straight
// to the output register, and the next input beat can be taken once they are loaded.
// The result sits in an output register: the next tick is accepted while it waits, and only
// the loading of the following result waits for the receiver to take the beat.
// The configuration channel is always ready; the user must write it only while no tick is
// in flight; the block does not check. Reset (arst_n low) restores the register defaults,
// sets the last mode to manual, clears both filter states and drops the output valid.
`timescale 1ns / 1ps
`default_nettype none

module flight_mode_target_smoother import fmts_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration write channel.
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	// Input ticks.
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// stick_roll, stick_pitch, stick_throttle, auto_roll, auto_pitch, auto_throttle, tick_us
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	// flight_mode
	input  wire logic [MODE_W-1:0]    s_axis_tuser,
	// Results.
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// roll_target, pitch_target, throttle_pwm
	output logic [OUT_DATA_W-1:0]     m_axis_tdata,
	// pid_bypass, pid_reset
	output logic [OUT_USER_W-1:0]     m_axis_tuser
);

	fmts_cmd_t cmd;
	fmts_sts_t sts;

	// Register writes never stall.
	assign cfg_ready = 1'b1;

	fmts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fmts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_dat   (cfg_data),
		.in_data   (s_axis_tdata),
		.in_mode   (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

`default_nettype wire

FILE: rtl/core/fmts_chk.sv
// Port-level assertions for the flight mode target smoother, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fmts_chk import fmts_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [OUT_USER_W-1:0] m_axis_tuser
);

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= 1'b1;
		end
	end

	// One tick at a time: input ready drops right after a beat is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a tick is still in progress");

	// The input side reopens only together with a result being presented.
	a_result_on_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q && $rose(s_axis_tready) |-> m_axis_tvalid)
		else $error("input reopened without a result beat");

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

endmodule

bind flight_mode_target_smoother fmts_chk u_fmts_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
